[rtl/iee_pkg.sv]
// Package for the integer expression evaluator: status codes, parse phases,
// character classes and controller/datapath command and status structs.
// No dependencies.
package iee_pkg;

   localparam int LineMaxDefault = 64;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_SYNTAX  = 3'd1;
   localparam logic [2:0] ST_UNKOP   = 3'd2;
   localparam logic [2:0] ST_RANGE   = 3'd3;
   localparam logic [2:0] ST_DIVZERO = 3'd4;
   localparam logic [2:0] ST_TOOLONG = 3'd5;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   typedef enum logic [7:0] {
      PH_LEAD1  = 8'b0000_0001,
      PH_SIGN1  = 8'b0000_0010,
      PH_DIG1   = 8'b0000_0100,
      PH_AFTER1 = 8'b0000_1000,
      PH_LEAD2  = 8'b0001_0000,
      PH_SIGN2  = 8'b0010_0000,
      PH_DIG2   = 8'b0100_0000,
      PH_TRAIL  = 8'b1000_0000
   } phase_type;

   typedef enum logic [4:0] {
      CS_PARSE = 5'b00001,
      CS_CALC  = 5'b00010,
      CS_DIV   = 5'b00100,
      CS_CHECK = 5'b01000,
      CS_OUT   = 5'b10000
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic       clear;       // end of line: clear operand state
      logic       digit;       // accumulate a digit
      logic       start_op;    // clear magnitude, set sign
      logic       neg;         // sign for start_op
      logic       latch_a;     // first operand <- current operand
      logic       set_op;
      logic [1:0] op;
      logic       calc;        // start evaluation
      logic [3:0] dval;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic        digit_ovf;  // next digit would overflow
      logic        done;       // evaluation finished
      logic [2:0]  calc_status;
      logic [31:0] calc_value;
   } dp_stat_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'd32) || (c == 8'd9);
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= 8'd48) && (c <= 8'd57);
   endfunction

endpackage

[rtl/iee_datapath.sv]
// Datapath of the expression evaluator: operand accumulation with range
// check, add/sub, multiplier and a radix-2 restoring divider.
// Depends on iee_pkg.
module iee_datapath
   import iee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat
);

   logic [31:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [31:0] a_ff, a_in;
   logic [1:0]  op_ff, op_in;

   // evaluation sequencer
   typedef enum logic [3:0] {
      EV_IDLE = 4'b0001,
      EV_MUL  = 4'b0010,
      EV_DIV  = 4'b0100,
      EV_DONE = 4'b1000
   } ev_type;
   ev_type      ev_ff, ev_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [2:0]  st_ff, st_in;
   logic [31:0] val_ff, val_in;
   logic        qneg_ff, qneg_in;

   logic [31:0] limit, mag10, b_bits, ua, ub;
   logic [32:0] limsub, trial;
   logic [32:0] sum33;
   logic        ovf;

   assign limit  = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
   assign limsub = {1'b0, limit} - {29'd0, cmd.dval};
   assign mag10  = (mag_ff << 3) + (mag_ff << 1);
   // magnitude > (limit-d)/10  <=>  10*mag > limit-d, with mag <= 214748364 guard
   assign ovf    = (mag_ff > 32'd214748364) ||
                   ({1'b0, mag10} > limsub);
   assign b_bits = neg_ff ? (32'd0 - mag_ff) : mag_ff;
   assign ua     = a_ff[31] ? (32'd0 - a_ff) : a_ff;
   assign ub     = b_bits[31] ? (32'd0 - b_bits) : b_bits;
   assign sum33  = (op_ff == OP_ADD)
                   ? ({a_ff[31], a_ff} + {b_bits[31], b_bits})
                   : ({a_ff[31], a_ff} - {b_bits[31], b_bits});
   assign trial  = {rem_ff[31:0], dvd_ff[31]} - {1'b0, dvs_ff};

   function automatic logic qneg_in_ok(input logic n, input logic [31:0] q);
      return n || !q[31];
   endfunction

   always_comb begin
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      a_in    = a_ff;
      op_in   = op_ff;
      ev_in   = ev_ff;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      st_in   = st_ff;
      val_in  = val_ff;
      qneg_in = qneg_ff;
      if (cmd.start_op) begin
         mag_in = '0;
         neg_in = cmd.neg;
      end
      // a first digit starts from an empty magnitude
      if (cmd.digit) begin
         if (cmd.start_op) mag_in = {28'd0, cmd.dval};
         else if (!ovf) mag_in = mag10 + {28'd0, cmd.dval};
      end
      if (cmd.latch_a) a_in = b_bits;
      if (cmd.set_op) op_in = cmd.op;
      unique case (ev_ff)
         EV_IDLE: begin
            if (cmd.calc) begin
               st_in  = ST_OK;
               val_in = '0;
               unique case (op_ff)
                  OP_ADD, OP_SUB: begin
                     if (sum33[32] != sum33[31]) st_in = ST_RANGE;
                     else val_in = sum33[31:0];
                     ev_in = EV_DONE;
                  end
                  OP_MUL: begin
                     prod_in = $signed(a_ff) * $signed(b_bits);
                     ev_in   = EV_MUL;
                  end
                  default: begin
                     if (b_bits == '0) begin
                        st_in = ST_DIVZERO;
                        ev_in = EV_DONE;
                     end else begin
                        dvd_in  = ua;
                        dvs_in  = ub;
                        rem_in  = '0;
                        quo_in  = '0;
                        cnt_in  = '0;
                        qneg_in = a_ff[31] ^ b_bits[31];
                        ev_in   = EV_DIV;
                     end
                  end
               endcase
            end
         end
         EV_MUL: begin
            if (prod_ff[63:31] != {33{prod_ff[31]}}) st_in = ST_RANGE;
            else val_in = prod_ff[31:0];
            ev_in = EV_DONE;
         end
         EV_DIV: begin
            if (!trial[32]) begin
               rem_in = trial;
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], dvd_ff[31]};
               quo_in = {quo_ff[30:0], 1'b0};
            end
            dvd_in = {dvd_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               // only -2^31 / -1 leaves the range
               if (!qneg_in_ok(qneg_ff, quo_in)) st_in = ST_RANGE;
               else val_in = qneg_ff ? (32'd0 - quo_in) : quo_in;
               ev_in = EV_DONE;
            end
         end
         default: ev_in = EV_IDLE;
      endcase
      if (cmd.clear) begin
         mag_in = '0;
         neg_in = 1'b0;
         a_in   = '0;
         op_in  = OP_ADD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff <= '0;
         neg_ff <= 1'b0;
         a_ff   <= '0;
         op_ff  <= OP_ADD;
         ev_ff  <= EV_IDLE;
      end else begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         a_ff   <= a_in;
         op_ff  <= op_in;
         ev_ff  <= ev_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      st_ff   <= st_in;
      val_ff  <= val_in;
      qneg_ff <= qneg_in;
   end

   assign stat.digit_ovf   = ovf;
   assign stat.done        = (ev_ff == EV_DONE);
   assign stat.calc_status = st_ff;
   assign stat.calc_value  = val_ff;

   property p_mag_range;
      @(posedge clock) disable iff (reset)
         mag_ff <= 32'h8000_0000;
   endproperty
   a_mag_range: assert property (p_mag_range) else $error("magnitude out of range");

   a_ok_has_value: assert property (@(posedge clock) disable iff (reset)
      (ev_ff == EV_DONE && st_ff != ST_OK) |-> val_ff == '0)
      else $error("error result carries a value");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (ev_ff == EV_DIV && cnt_ff == 5'd31) |=> ev_ff == EV_DONE)
      else $error("divider did not finish");

endmodule

[rtl/iee_control.sv]
// Controller of the expression evaluator: handshakes, line length count,
// parse phase tracking and first-error capture.
// Depends on iee_pkg.
module iee_control
   import iee_pkg::*;
#(
   parameter int LINE_MAX = LineMaxDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   localparam int CW = $clog2(LINE_MAX + 1);

   ctrl_state_type state_ff, state_in;
   phase_type      ph_ff, ph_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [2:0]     err_ff, err_in;
   logic           ov_ff, ov_in;
   logic [2:0]     ost_ff, ost_in;
   logic [31:0]    oval_ff, oval_in;

   logic [7:0] c;
   logic       acc, blank, dig, isop;
   logic [1:0] opk;

   assign c     = req_tdata;
   assign blank = is_blank(c);
   assign dig   = is_dig(c);
   assign req_tready = (state_ff == CS_PARSE) && !ov_ff;
   assign acc   = req_tvalid && req_tready;

   always_comb begin
      isop = 1'b1;
      opk  = OP_ADD;
      unique case (c)
         8'd43:   opk = OP_ADD;
         8'd45:   opk = OP_SUB;
         8'd42:   opk = OP_MUL;
         8'd47:   opk = OP_DIV;
         default: isop = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      ov_in    = ov_ff;
      ost_in   = ost_ff;
      oval_in  = oval_ff;
      cmd      = '0;
      cmd.dval = c[3:0];
      cmd.op   = opk;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      unique case (state_ff)
         CS_PARSE: begin
            if (acc && c != 8'd0) begin
               if (cnt_ff < CW'(LINE_MAX)) cnt_in = cnt_ff + CW'(1);
               if (err_ff == ST_OK) begin
                  unique case (ph_ff)
                     PH_LEAD1, PH_LEAD2: begin
                        cmd.start_op = 1'b1;
                        if (blank) begin
                        end else if (c == 8'd43 || c == 8'd45) begin
                           cmd.neg = (c == 8'd45);
                           ph_in = (ph_ff == PH_LEAD1) ? PH_SIGN1 : PH_SIGN2;
                        end else if (dig) begin
                           ph_in = (ph_ff == PH_LEAD1) ? PH_DIG1 : PH_DIG2;
                        end else err_in = ST_SYNTAX;
                     end
                     PH_SIGN1, PH_SIGN2, PH_DIG2: begin
                        if (dig) begin
                           if (ph_ff == PH_SIGN1) ph_in = PH_DIG1;
                           if (ph_ff == PH_SIGN2) ph_in = PH_DIG2;
                        end else if (ph_ff == PH_DIG2 && blank) ph_in = PH_TRAIL;
                        else err_in = ST_SYNTAX;
                     end
                     PH_DIG1: begin
                        if (!dig) begin
                           cmd.latch_a = 1'b1;
                           if (blank) ph_in = PH_AFTER1;
                           else if (isop) begin
                              cmd.set_op = 1'b1;
                              ph_in = PH_LEAD2;
                           end else err_in = ST_UNKOP;
                        end
                     end
                     PH_AFTER1: begin
                        if (blank) begin
                        end else if (dig) err_in = ST_SYNTAX;
                        else if (isop) begin
                           cmd.set_op = 1'b1;
                           ph_in = PH_LEAD2;
                        end else err_in = ST_UNKOP;
                     end
                     default: if (!blank) err_in = ST_SYNTAX;
                  endcase
               end
               // digit accumulation happens in the datapath, sign cleared first
               if (err_ff == ST_OK && dig && ph_ff != PH_AFTER1 && ph_ff != PH_TRAIL) begin
                  if (stat.digit_ovf && !(ph_ff == PH_LEAD1 || ph_ff == PH_LEAD2))
                     err_in = ST_RANGE;
                  else cmd.digit = 1'b1;
               end
            end else if (acc) begin
               if (cnt_ff >= CW'(LINE_MAX)) begin
                  ost_in = ST_TOOLONG; oval_in = '0; state_in = CS_OUT;
               end else if (err_ff != ST_OK) begin
                  ost_in = err_ff; oval_in = '0; state_in = CS_OUT;
               end else if (ph_ff == PH_DIG2 || ph_ff == PH_TRAIL) begin
                  cmd.calc = 1'b1; state_in = CS_CALC;
               end else begin
                  ost_in = ST_SYNTAX; oval_in = '0; state_in = CS_OUT;
               end
            end
         end
         CS_CALC: begin
            if (stat.done) begin
               ost_in = stat.calc_status; oval_in = stat.calc_value;
               state_in = CS_OUT;
            end
         end
         CS_OUT: begin
            cmd.clear = 1'b1;
            ph_in  = PH_LEAD1;
            cnt_in = '0;
            err_in = ST_OK;
            ov_in  = 1'b1;
            state_in = CS_PARSE;
         end
         default: state_in = CS_PARSE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_PARSE;
         ph_ff    <= PH_LEAD1;
         cnt_ff   <= '0;
         err_ff   <= ST_OK;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      ost_ff  <= ost_in;
      oval_ff <= oval_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {5'd0, oval_ff, ost_ff};

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != CS_PARSE) |-> !req_tready)
      else $error("input taken while evaluating");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK && state_ff == CS_PARSE && !(acc && c == 8'd0))
      |=> err_ff == $past(err_ff))
      else $error("first error overwritten");

   a_cnt_sat: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(LINE_MAX))
      else $error("length count beyond limit");

endmodule

[rtl/int_expression_evaluator.sv]
// Integer expression evaluator: one character per transaction in, one
// status/result transaction per line out. Uses iee_pkg, iee_control, iee_datapath.
// On the terminator, + and - are computed directly, * goes through a product
// register and / through a 32-step divider; a line already in error skips
// evaluation. Throughput: one character per cycle inside a line; input stalls
// while a line is evaluated and until its result is taken.
// Reset (synchronous, high) empties the line and drops any result.
module int_expression_evaluator
   import iee_pkg::*;
#(
   parameter int LINE_MAX = LineMaxDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [2:0] status, [34:3] result_value
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   iee_control #(.LINE_MAX(LINE_MAX)) u_control (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .cmd, .stat
   );

   iee_datapath u_datapath (.clock, .reset, .cmd, .stat);

endmodule

[sim/int_expression_evaluator_test.sv]
// Testbench for int_expression_evaluator: drives text lines one character per
// transaction and checks each status/result against a built-in line parser.
// Depends on iee_pkg and the RTL of the evaluator.
`timescale 1ns / 100ps

module int_expression_evaluator_test;
   import iee_pkg::*;

   localparam int LineMax = LineMaxDefault;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value;
   } verdict_type;

   int  mismatches = 0;

   task automatic report_mismatch(string what, longint want, longint got);
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
      mismatches++;
   endtask

   class line_scoreboard;
      // parser state
      int unsigned phase;      // 0 lead1 .. 7 trail
      int unsigned count;
      bit [31:0]   mag;
      bit          neg;
      bit [31:0]   opnd_a;
      logic [1:0]  op;
      logic [2:0]  err;
      verdict_type pending[$];

      function void clear_line();
         phase = 0;
         count = 0;
         mag = 0;
         neg = 0;
         opnd_a = 0;
         op = OP_ADD;
         err = ST_OK;
      endfunction

      function bit blank(bit [7:0] c);
         return c == 8'd32 || c == 8'd9;
      endfunction

      function bit digit(bit [7:0] c);
         return c >= 8'd48 && c <= 8'd57;
      endfunction

      function void push_digit(bit [7:0] c);
         bit [31:0] d;
         bit [31:0] lim;
         d = c - 8'd48;
         lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
         if (mag > (lim - d) / 10) err = ST_RANGE;
         else mag = mag * 10 + d;
      endfunction

      function void take_op(bit [7:0] c);
         case (c)
            8'd43: op = OP_ADD;
            8'd45: op = OP_SUB;
            8'd42: op = OP_MUL;
            8'd47: op = OP_DIV;
            default: begin
               err = ST_UNKOP;
               return;
            end
         endcase
         phase = 4;
      endfunction

      function void begin_operand(bit [7:0] c);
         mag = 0;
         neg = 0;
         if (blank(c)) return;
         if (c == 8'd43 || c == 8'd45) begin
            neg = (c == 8'd45);
            phase = phase + 1;
         end else if (digit(c)) begin
            phase = phase + 2;
            push_digit(c);
         end else begin
            err = ST_SYNTAX;
         end
      endfunction

      function bit [31:0] signed_opnd();
         return neg ? (32'd0 - mag) : mag;
      endfunction

      function verdict_type evaluate();
         longint a, b, r;
         verdict_type v;
         a = longint'(signed'(opnd_a));
         b = longint'(signed'(signed_opnd()));
         v = '0;
         case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            default: begin
               if (b == 0) begin
                  v.status = ST_DIVZERO;
                  return v;
               end
               r = a / b;
            end
         endcase
         if (r > 64'sd2147483647 || r < -64'sd2147483648) v.status = ST_RANGE;
         else v.value = r[31:0];
         return v;
      endfunction

      // note an accepted character
      function void note_char(bit [7:0] c);
         verdict_type v;
         if (c != 0) begin
            if (count < LineMax) count++;
            if (err != ST_OK) return;
            case (phase)
               0, 4: begin_operand(c);
               1, 5: if (digit(c)) begin
                  phase = phase + 1;
                  push_digit(c);
               end else err = ST_SYNTAX;
               2: if (digit(c)) push_digit(c);
               else begin
                  opnd_a = signed_opnd();
                  if (blank(c)) phase = 3;
                  else take_op(c);
               end
               3: if (digit(c)) err = ST_SYNTAX;
               else if (!blank(c)) take_op(c);
               6: if (digit(c)) push_digit(c);
               else if (blank(c)) phase = 7;
               else err = ST_SYNTAX;
               default: if (!blank(c)) err = ST_SYNTAX;
            endcase
            return;
         end
         v = '0;
         if (count >= LineMax) v.status = ST_TOOLONG;
         else if (err != ST_OK) v.status = err;
         else if (phase == 6 || phase == 7) v = evaluate();
         else v.status = ST_SYNTAX;
         pending.push_back(v);
         clear_line();
      endfunction

      task check_result(logic [39:0] data);
         verdict_type want;
         if (pending.size() == 0) begin
            report_mismatch("result with no line pending", 0, data[2:0]);
            return;
         end
         want = pending.pop_front();
         if (data[2:0] !== want.status)
            report_mismatch("status", want.status, data[2:0]);
         if (data[34:3] !== want.value)
            report_mismatch("result_value", want.value, data[34:3]);
         if (data[39:35] !== 5'd0)
            report_mismatch("padding", 0, data[39:35]);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   line_scoreboard sb;
   bit  quiet = 1'b0;     // no idling near the end of the run
   bit  driving = 1'b1;

   int_expression_evaluator u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sender: one character per transaction
   task automatic send_char(bit [7:0] c);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      sb.note_char(c);
      @(negedge clock);
   endtask

   task automatic send_line(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
      send_char(8'd0);
   endtask

   function automatic string num_text(int v);
      string s;
      s.itoa(v);
      return s;
   endfunction

   function automatic string pad();
      string s;
      s = "";
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(0, 1)) s = {s, " "};
         else s = {s, "\t"};
      end
      return s;
   endfunction

   function automatic int pick_operand();
      case ($urandom_range(0, 5))
         0: return int'($urandom);
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return 32'h7fff_ffff - $urandom_range(0, 3);
         3: return $urandom_range(0, 20) - 10;
         default: return $urandom_range(0, 100000) - 50000;
      endcase
   endfunction

   function automatic string op_text();
      case ($urandom_range(0, 3))
         0: return "+";
         1: return "-";
         2: return "*";
         default: return "/";
      endcase
   endfunction

   function automatic string well_formed();
      string s, a, b;
      a = num_text(pick_operand());
      b = num_text(pick_operand());
      if (a[0] != "-" && $urandom_range(0, 3) == 0) a = {"+", a};
      if (b[0] != "-" && $urandom_range(0, 3) == 0) b = {"+", b};
      s = {pad(), a, pad(), op_text(), pad(), b, pad()};
      return s;
   endfunction

   function automatic string noisy();
      string s;
      int n;
      s = well_formed();
      case ($urandom_range(0, 3))
         0: begin   // corrupt one character with any non-zero byte
            n = $urandom_range(0, s.len() - 1);
            s[n] = 8'($urandom_range(1, 255));
         end
         1: s = s.substr(0, $urandom_range(0, s.len() - 1) - 1);
         2: begin
            s = "";
            repeat ($urandom_range(0, 12)) s = {s, string'(byte'($urandom_range(1, 255)))};
         end
         default: repeat ($urandom_range(40, 70)) s = {s, " "};
      endcase
      return s;
   endfunction

   // receiver
   initial begin
      @(negedge clock);
      while (1) begin
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_tready <= (quiet || $urandom_range(0, 4) != 0);
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         @(negedge clock);
      end
   end

   initial begin
      #50ms;
      $display("FAIL");
      $finish;
   end

   initial begin
      string s;
      sb = new();
      sb.clear_line();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_line("2147483647+0");
      send_line("-2147483648-1");
      send_line("2147483648+1");
      send_line("-2147483649 + 1");
      send_line("  -2147483648 / -1 ");
      send_line("\t12 * -3\t");
      send_line("7/-2");
      send_line("5 / 0");
      send_line("- 5+1");
      send_line("3 4+1");
      send_line("3 % 4");
      send_line("3+");
      send_line("3+4x");
      send_line("");
      send_line("46341*46341");
      send_line("-65536*32768");
      send_line("+1-+1");
      s = "1+1";
      repeat (61) s = {s, " "};
      send_line(s);
      s = "1+1";
      repeat (60) s = {s, " "};
      send_line(s);
      send_line({"\x80\xff", "1+1"});
      send_line("99999999999 / 0");

      // pause until every pending result is back
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);

      for (int i = 0; i < 62; i++) begin
         if (i == 52) quiet = 1'b1;
         if ($urandom_range(0, 3) == 0) s = noisy();
         else s = well_formed();
         send_line(s);
      end
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (mismatches == 0 && sb.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
